>>> hdl/ipv4_header_parser_macros.svh
// assertion helpers for the ipv4 header parser
// each expects clk and rst_n in scope
`ifndef IPV4_HEADER_PARSER_MACROS_SVH
`define IPV4_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define IPHP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4 header parser check failed");

// next-cycle implication
`define IPHP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4 header parser check failed");

`endif

>>> hdl/iphp_pkg.sv
`timescale 1ns / 1ps

package iphp_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CUT   = 2'd1,
    ST_TRUNC = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // byte positions inside the base header
  localparam logic [15:0] IDX_VER_IHL   = 16'd0;
  localparam logic [15:0] IDX_LEN_HI    = 16'd2;
  localparam logic [15:0] IDX_LEN_LO    = 16'd3;
  localparam logic [15:0] IDX_ID_HI     = 16'd4;
  localparam logic [15:0] IDX_ID_LO     = 16'd5;
  localparam logic [15:0] IDX_FF_HI     = 16'd6;
  localparam logic [15:0] IDX_FF_LO     = 16'd7;
  localparam logic [15:0] IDX_TTL       = 16'd8;
  localparam logic [15:0] IDX_PROTO     = 16'd9;
  localparam logic [15:0] IDX_CK_HI     = 16'd10;
  localparam logic [15:0] IDX_CK_LO     = 16'd11;
  localparam logic [15:0] IDX_SRC_FIRST = 16'd12;
  localparam logic [15:0] IDX_SRC_LAST  = 16'd15;
  localparam logic [15:0] IDX_DST_FIRST = 16'd16;
  localparam logic [15:0] IDX_DST_LAST  = 16'd19;

  localparam logic [15:0] BASE_HEADER_BYTES = 16'd20;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
  localparam logic [3:0]  VER_IPV4          = 4'd4;
  localparam logic [3:0]  MIN_IHL           = 4'd5;

  // one finished capture, handed from front to back
  typedef struct packed {
    logic [15:0] cap;
    logic [15:0] base_offset;
    logic [7:0]  version_ihl;
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [15:0] flags_frag;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] checksum;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_rec_t;

endpackage

>>> hdl/iphp_front.sv
`timescale 1ns / 1ps

module iphp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  logic              in_tuser,
  input  logic              in_tlast,
  output logic              push_valid,
  input  logic              push_ready,
  output iphp_pkg::hdr_rec_t push_rec
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] base_offset_r, base_offset_nxt;
  logic [7:0]  version_ihl_r, version_ihl_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] cksum_r, cksum_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] idx;
  logic [15:0] count_inc;
  logic [7:0]  b;
  logic        accept;

  assign b         = in_tdata[7:0];
  assign in_tready = push_ready;
  assign accept    = in_tvalid && push_ready;
  assign push_valid = in_tvalid && in_tlast;

  always_comb begin
    // first byte restarts the count and clears the captured header
    if (in_tuser) begin
      idx             = '0;
      base_offset_nxt = in_tdata[23:8];
      version_ihl_nxt = '0;
      length_nxt      = '0;
      ident_nxt       = '0;
      flags_nxt       = '0;
      ttl_nxt         = '0;
      proto_nxt       = '0;
      cksum_nxt       = '0;
      src_nxt         = '0;
      dst_nxt         = '0;
    end else begin
      idx             = byte_count_r;
      base_offset_nxt = base_offset_r;
      version_ihl_nxt = version_ihl_r;
      length_nxt      = length_r;
      ident_nxt       = ident_r;
      flags_nxt       = flags_r;
      ttl_nxt         = ttl_r;
      proto_nxt       = proto_r;
      cksum_nxt       = cksum_r;
      src_nxt         = src_r;
      dst_nxt         = dst_r;
    end

    case (idx)
      iphp_pkg::IDX_VER_IHL: version_ihl_nxt = b;
      iphp_pkg::IDX_LEN_HI,
      iphp_pkg::IDX_LEN_LO:  length_nxt = {length_nxt[7:0], b};
      iphp_pkg::IDX_ID_HI,
      iphp_pkg::IDX_ID_LO:   ident_nxt = {ident_nxt[7:0], b};
      iphp_pkg::IDX_FF_HI,
      iphp_pkg::IDX_FF_LO:   flags_nxt = {flags_nxt[7:0], b};
      iphp_pkg::IDX_TTL:     ttl_nxt = b;
      iphp_pkg::IDX_PROTO:   proto_nxt = b;
      iphp_pkg::IDX_CK_HI,
      iphp_pkg::IDX_CK_LO:   cksum_nxt = {cksum_nxt[7:0], b};
      default: begin
        if (idx inside {[iphp_pkg::IDX_SRC_FIRST:iphp_pkg::IDX_SRC_LAST]}) begin
          src_nxt = {src_nxt[23:0], b};
        end else if (idx inside {[iphp_pkg::IDX_DST_FIRST:iphp_pkg::IDX_DST_LAST]}) begin
          dst_nxt = {dst_nxt[23:0], b};
        end
      end
    endcase

    // saturating byte counter
    count_inc = (idx == iphp_pkg::COUNT_MAX) ? idx : idx + 16'd1;
    byte_count_nxt = in_tlast ? '0 : count_inc;
  end

  always_comb begin
    push_rec.cap         = count_inc;
    push_rec.base_offset = base_offset_nxt;
    push_rec.version_ihl = version_ihl_nxt;
    push_rec.total_len   = length_nxt;
    push_rec.ident       = ident_nxt;
    push_rec.flags_frag  = flags_nxt;
    push_rec.ttl         = ttl_nxt;
    push_rec.proto       = proto_nxt;
    push_rec.checksum    = cksum_nxt;
    push_rec.src         = src_nxt;
    push_rec.dst         = dst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      base_offset_r <= '0;
      version_ihl_r <= '0;
      length_r      <= '0;
      ident_r       <= '0;
      flags_r       <= '0;
      ttl_r         <= '0;
      proto_r       <= '0;
      cksum_r       <= '0;
      src_r         <= '0;
      dst_r         <= '0;
    end else if (accept) begin
      byte_count_r  <= byte_count_nxt;
      base_offset_r <= base_offset_nxt;
      version_ihl_r <= version_ihl_nxt;
      length_r      <= length_nxt;
      ident_r       <= ident_nxt;
      flags_r       <= flags_nxt;
      ttl_r         <= ttl_nxt;
      proto_r       <= proto_nxt;
      cksum_r       <= cksum_nxt;
      src_r         <= src_nxt;
      dst_r         <= dst_nxt;
    end
  end

endmodule

>>> hdl/iphp_queue.sv
`timescale 1ns / 1ps

module iphp_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  iphp_pkg::hdr_rec_t push_rec,
  output logic               pop_valid,
  input  logic               pop_ready,
  output iphp_pkg::hdr_rec_t pop_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  iphp_pkg::hdr_rec_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

>>> hdl/iphp_back.sv
`timescale 1ns / 1ps

module iphp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  iphp_pkg::hdr_rec_t pop_rec,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [183:0]       out_tdata,
  output logic [1:0]         out_tuser
);

  logic                  out_valid_r;
  iphp_pkg::status_t     status_r, status_nxt;
  logic [15:0]           offset_r, offset_nxt;
  logic [5:0]            hbytes_r, hbytes_nxt;
  logic [15:0]           total_r, total_nxt;
  logic [15:0]           ident_r, ident_nxt;
  logic [14:0]           frag_r, frag_nxt;
  logic [7:0]            ttl_r, ttl_nxt;
  logic [7:0]            proto_r, proto_nxt;
  logic [15:0]           cksum_r, cksum_nxt;
  logic [31:0]           src_r, src_nxt;
  logic [31:0]           dst_r, dst_nxt;
  logic [15:0]           payload_r, payload_nxt;

  logic [3:0]  ihl;
  logic [5:0]  hl;
  logic [15:0] hl_w;
  logic [16:0] sum_cap, sum_two, sum_hl;
  logic [15:0] off_cap, off_two, off_hl;
  logic [15:0] avail;
  logic        do_pop;

  assign pop_ready = !out_valid_r || out_tready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    ihl  = pop_rec.version_ihl[3:0];
    hl   = {ihl, 2'b00};
    hl_w = {10'd0, hl};

    sum_cap = {1'b0, pop_rec.base_offset} + {1'b0, pop_rec.cap};
    sum_two = {1'b0, pop_rec.base_offset} + 17'd2;
    sum_hl  = {1'b0, pop_rec.base_offset} + {1'b0, hl_w};
    off_cap = sum_cap[16] ? iphp_pkg::COUNT_MAX : sum_cap[15:0];
    off_two = sum_two[16] ? iphp_pkg::COUNT_MAX : sum_two[15:0];
    off_hl  = sum_hl[16]  ? iphp_pkg::COUNT_MAX : sum_hl[15:0];
    avail   = (pop_rec.cap < pop_rec.total_len) ? pop_rec.cap : pop_rec.total_len;

    status_nxt  = iphp_pkg::ST_OK;
    offset_nxt  = off_hl;
    hbytes_nxt  = '0;
    total_nxt   = '0;
    ident_nxt   = '0;
    frag_nxt    = '0;
    ttl_nxt     = '0;
    proto_nxt   = '0;
    cksum_nxt   = '0;
    src_nxt     = '0;
    dst_nxt     = '0;
    payload_nxt = '0;

    if (pop_rec.cap < iphp_pkg::BASE_HEADER_BYTES) begin
      status_nxt = iphp_pkg::ST_TRUNC;
      offset_nxt = off_cap;
    end else if (pop_rec.version_ihl[7:4] != iphp_pkg::VER_IPV4 ||
                 ihl < iphp_pkg::MIN_IHL) begin
      status_nxt = iphp_pkg::ST_BAD;
      offset_nxt = pop_rec.base_offset;
    end else if (pop_rec.total_len < hl_w) begin
      status_nxt = iphp_pkg::ST_BAD;
      offset_nxt = off_two;
    end else if (pop_rec.cap < hl_w) begin
      status_nxt = iphp_pkg::ST_TRUNC;
      offset_nxt = off_cap;
    end else begin
      status_nxt  = (pop_rec.cap < pop_rec.total_len) ? iphp_pkg::ST_CUT : iphp_pkg::ST_OK;
      hbytes_nxt  = hl;
      total_nxt   = pop_rec.total_len;
      ident_nxt   = pop_rec.ident;
      frag_nxt    = pop_rec.flags_frag[14:0];
      ttl_nxt     = pop_rec.ttl;
      proto_nxt   = pop_rec.proto;
      cksum_nxt   = pop_rec.checksum;
      src_nxt     = pop_rec.src;
      dst_nxt     = pop_rec.dst;
      payload_nxt = avail - hl_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      status_r  <= status_nxt;
      offset_r  <= offset_nxt;
      hbytes_r  <= hbytes_nxt;
      total_r   <= total_nxt;
      ident_r   <= ident_nxt;
      frag_r    <= frag_nxt;
      ttl_r     <= ttl_nxt;
      proto_r   <= proto_nxt;
      cksum_r   <= cksum_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, payload_r, dst_r, src_r, cksum_r, proto_r, ttl_r,
                       frag_r, ident_r, total_r, hbytes_r, offset_r};

endmodule

>>> hdl/ipv4_header_parser.sv
`timescale 1ns / 1ps
// channel | dir | tdata (lsb first)                                  | tuser      | tlast
// in_     | in  | data_byte[7:0], network_offset[23:8]               | first_byte | last_byte
// out_    | out | report_offset, header_bytes, datagram_length,      | status     | -
//         |     | ident, fragment_info, time_to_live, upper_protocol,|            |
//         |     | checksum_field, src and dst address,               |            |
//         |     | payload_bytes, zero pad to 184 bits                |            |
//
// one input beat per cycle while in_tready is high; the capture front takes a byte every clock unless the queue is full
// after its last byte a result is registered in the queue, then in the output register
// rst_n is synchronous; it clears the byte counter, header registers and queue
// in_tready falls only when the result queue is full, i.e. the output is held off

module ipv4_header_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // data_byte[7:0], network_offset[23:8]
  input  logic         in_tuser,   // first_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata,  // report_offset[15:0], header_bytes[21:16],
                                   // datagram_length[37:22], ident[53:38],
                                   // fragment_info[68:54], time_to_live[76:69],
                                   // upper_protocol[84:77], checksum_field[100:85],
                                   // src_addr[132:101],
                                   // dst_addr[164:133],
                                   // payload_bytes[180:165], zero pad above
  output logic [1:0]   out_tuser   // status
);

  // front to queue
  logic               push_valid;
  logic               push_ready;
  iphp_pkg::hdr_rec_t push_rec;

  // queue to back
  logic               pop_valid;
  logic               pop_ready;
  iphp_pkg::hdr_rec_t pop_rec;

  // result classes and used length, for the checks below
  logic               out_is_err;
  logic               out_is_ok;
  logic [16:0]        out_used_len;

  // front: counts bytes and shifts the base header in, hands over at the last byte
  iphp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  // short queue of finished captures so front and back stall apart
  iphp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  // back: status checks, saturating offsets and the output register
  iphp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign out_is_err   = out_tvalid && (out_tuser == iphp_pkg::ST_TRUNC ||
                                       out_tuser == iphp_pkg::ST_BAD);
  assign out_is_ok    = out_tvalid && (out_tuser == iphp_pkg::ST_OK ||
                                       out_tuser == iphp_pkg::ST_CUT);
  assign out_used_len = {1'b0, out_tdata[180:165]} + {11'd0, out_tdata[21:16]};

`include "ipv4_header_parser_macros.svh"

  // a full queue always has something to hand over
  `IPHP_ASSERT_IMPL(a_full_not_empty, !push_ready, pop_valid)

  // error results carry nothing but status and offset
  `IPHP_ASSERT_IMPL(a_err_fields_zero, out_is_err, out_tdata[180:16] == '0)

  // on success the payload and header fit inside the total length
  `IPHP_ASSERT_IMPL(a_ok_len_fits, out_is_ok, out_used_len <= {1'b0, out_tdata[37:22]})

  // with the output held, a full queue stays full
  `IPHP_ASSERT_NEXT(a_full_holds, !push_ready && out_tvalid && !out_tready, !push_ready)

endmodule
